FILE: hw/rtl/cma_pkg.sv
// shared types and constants for the centered moving average block
// no dependencies; used by the top level only
package cma_pkg;

  // width of the window length register
  localparam int CFG_W = 6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_WAIT,
    ST_OUT
  } state_t;

endpackage

FILE: hw/rtl/cma_store.sv
// sample store: single write port, single read port, registered read data
// no package dependencies
module cma_store #(
  parameter int DEPTH  = 64,
  parameter int DATA_W = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/cma_div.sv
// iterative signed divider, one quotient bit per cycle, truncates toward zero
// divisor is unsigned and nonzero; no package dependencies
module cma_div #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 7
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] dividend,
  input  logic        [DEN_W-1:0] divisor,
  output logic                    done,
  output logic signed [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] qmag;
  logic             neg;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_dif;
  logic             fits;

  always_comb begin
    rem_sh   = {rem, qmag[NUM_W-1]};
    rem_dif  = rem_sh - {1'b0, den};
    fits     = rem_sh >= {1'b0, den};
    quotient = neg ? -$signed(qmag) : $signed(qmag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
        rem  <= '0;
        den  <= divisor;
        neg  <= dividend[NUM_W-1];
        // magnitude of the most negative value still fits unsigned
        qmag <= dividend[NUM_W-1] ? -dividend : dividend;
      end else if (busy) begin
        rem  <= fits ? rem_dif[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        qmag <= {qmag[NUM_W-2:0], fits};
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/centered_moving_average_edge_hold.sv
// Centered moving average with edge hold over a finite streamed signal.
// Input channel (in_valid/in_ready): sample, end_of_signal marks the last one.
// Output channel (out_valid/out_ready): smoothed, last_of_run on the final
// output of a signal. Config: window_wr_en/window_wr_data write the window
// length, taken at the first sample of each signal (0 acts as 1, values above
// MAX_WINDOW saturate). Write it only while the block is idle.
// Samples live in a MAX_WINDOW+1 entry synchronous store; each output reads
// the 2q+1 window entries one per cycle, then runs a bit-serial divide.
// Each output goes through the window reads and accumulation, then the divide,
// then the handoff to the output channel. A sample that gives no output is
// only written to the store while the block stays idle. The final sample of a
// signal produces up to q+1 outputs in turn, each with its own window walk.
// Only one transaction is in flight: in_ready is low while a result is being
// computed or held, and a stalled receiver holds the block with the result
// steady on the output ports. Reset returns to idle, window length 1, and
// clears the sample count; the store needs no clearing pass.
module centered_moving_average_edge_hold #(
  parameter int MAX_WINDOW   = 63,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           window_wr_en,
  input  logic [cma_pkg::CFG_W-1:0]      window_wr_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           end_of_signal,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] smoothed,
  output logic                           last_of_run
);

  localparam int DEPTH  = MAX_WINDOW + 1;
  localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
  localparam int ADDR_W = WIN_W;
  localparam int SEEN_W = WIN_W + 1;
  localparam int D_W    = WIN_W + 2;
  localparam int SUM_W  = SAMPLE_WIDTH + WIN_W + 2;
  localparam int DEN_W  = WIN_W + 1;
  localparam int CMP_W  = (WIN_W > cma_pkg::CFG_W) ? WIN_W : cma_pkg::CFG_W;

  cma_pkg::state_t state, state_next;

  logic [cma_pkg::CFG_W-1:0] window_reg;
  logic [WIN_W-1:0]          active_w;
  logic [SEEN_W-1:0]         samples_seen;
  logic [ADDR_W-1:0]         newest;
  logic [SEEN_W-1:0]         cur_n;
  logic                      cur_last;
  logic [WIN_W-1:0]          e_pos;
  logic [WIN_W-1:0]          k;
  logic                      issue_done;
  logic                      rd_pend;
  logic                      rd_half;
  logic signed [SUM_W-1:0]   acc;
  logic [SAMPLE_WIDTH-1:0]   smoothed_reg;
  logic                      last_reg;

  // accept-time values
  logic [CMP_W-1:0]  wl_ext;
  logic [WIN_W-1:0]  w_eff;
  logic [WIN_W-1:0]  w_new;
  logic [WIN_W-1:0]  q_new;
  logic [ADDR_W-1:0] newest_new;
  logic              has_result;
  logic              accept;

  // window walk
  logic [WIN_W-1:0]        q;
  logic [WIN_W-1:0]        two_q;
  logic signed [D_W-1:0]   d;
  logic [SEEN_W-1:0]       ud;
  logic [ADDR_W-1:0]       ud_a;
  logic [ADDR_W:0]         idx_wide;
  logic                    half_k;
  logic [SAMPLE_WIDTH-1:0] rd_data;
  logic signed [SUM_W-1:0] rd_ext;
  logic signed [SUM_W-1:0] term;

  logic                    div_start;
  logic                    div_done;
  logic signed [SUM_W-1:0] div_quot;

  always_comb begin
    wl_ext = CMP_W'(window_reg);
    if (wl_ext == '0) begin
      w_eff = WIN_W'(1);
    end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
      w_eff = WIN_W'(MAX_WINDOW);
    end else begin
      w_eff = wl_ext[WIN_W-1:0];
    end
    w_new = (samples_seen == '0) ? w_eff : active_w;
    q_new = w_new >> 1;
    if (samples_seen == '0) begin
      newest_new = '0;
    end else if (newest == ADDR_W'(DEPTH - 1)) begin
      newest_new = '0;
    end else begin
      newest_new = newest + 1'b1;
    end
    has_result = end_of_signal || (samples_seen >= SEEN_W'(q_new));
    accept     = (state == cma_pkg::ST_IDLE) && in_valid;
  end

  always_comb begin
    q      = active_w >> 1;
    two_q  = {active_w[WIN_W-1:1], 1'b0};
    half_k = !active_w[0] && ((k == '0) || (k == two_q));
    // back distance from the newest sample, held at both signal ends
    d = $signed(D_W'(e_pos)) + $signed(D_W'(q)) - $signed(D_W'(k));
    if (d[D_W-1]) begin
      ud = '0;
    end else if (d > $signed(D_W'(cur_n))) begin
      ud = cur_n;
    end else begin
      ud = d[SEEN_W-1:0];
    end
    ud_a = ud[ADDR_W-1:0];
    if (newest >= ud_a) begin
      idx_wide = {1'b0, newest} - {1'b0, ud_a};
    end else begin
      idx_wide = {1'b0, newest} + (ADDR_W + 1)'(DEPTH) - {1'b0, ud_a};
    end
    rd_ext = {{(SUM_W - SAMPLE_WIDTH){rd_data[SAMPLE_WIDTH-1]}}, rd_data};
    term   = rd_half ? rd_ext : (rd_ext <<< 1);
  end

  cma_store #(
    .DEPTH (DEPTH),
    .DATA_W(SAMPLE_WIDTH),
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk    (clk),
    .wr_en  (accept),
    .wr_addr(newest_new),
    .wr_data(sample),
    .rd_en  ((state == cma_pkg::ST_SUM) && !issue_done),
    .rd_addr(idx_wide[ADDR_W-1:0]),
    .rd_data(rd_data)
  );

  cma_div #(
    .NUM_W(SUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(acc),
    .divisor ({active_w, 1'b0}),
    .done    (div_done),
    .quotient(div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cma_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      cma_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && has_result) begin
          state_next = cma_pkg::ST_SUM;
        end
      end
      cma_pkg::ST_SUM: begin
        if (issue_done && !rd_pend) begin
          state_next = cma_pkg::ST_DIV;
        end
      end
      cma_pkg::ST_DIV: begin
        div_start  = 1'b1;
        state_next = cma_pkg::ST_WAIT;
      end
      cma_pkg::ST_WAIT: begin
        if (div_done) begin
          state_next = cma_pkg::ST_OUT;
        end
      end
      cma_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = (cur_last && (e_pos != '0)) ? cma_pkg::ST_SUM : cma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cma_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_reg   <= cma_pkg::CFG_W'(1);
      active_w     <= WIN_W'(1);
      samples_seen <= '0;
      newest       <= '0;
      k            <= '0;
      issue_done   <= 1'b0;
      rd_pend      <= 1'b0;
    end else begin
      if (window_wr_en) begin
        window_reg <= window_wr_data;
      end
      unique case (state)
        cma_pkg::ST_IDLE: begin
          if (in_valid) begin
            active_w   <= w_new;
            newest     <= newest_new;
            cur_n      <= samples_seen;
            cur_last   <= end_of_signal;
            k          <= '0;
            issue_done <= 1'b0;
            rd_pend    <= 1'b0;
            acc        <= '0;
            if (end_of_signal) begin
              samples_seen <= '0;
              // flush starts at the oldest pending center
              e_pos <= (samples_seen < SEEN_W'(q_new)) ? samples_seen[WIN_W-1:0] : q_new;
            end else begin
              e_pos <= q_new;
              if (samples_seen != '1) begin
                samples_seen <= samples_seen + 1'b1;
              end
            end
          end
        end
        cma_pkg::ST_SUM: begin
          rd_pend <= !issue_done;
          rd_half <= half_k;
          if (!issue_done) begin
            k <= k + 1'b1;
            if (k == two_q) begin
              issue_done <= 1'b1;
            end
          end
          if (rd_pend) begin
            acc <= acc + term;
          end
        end
        cma_pkg::ST_WAIT: begin
          if (div_done) begin
            smoothed_reg <= div_quot[SAMPLE_WIDTH-1:0];
            last_reg     <= cur_last && (e_pos == '0);
          end
        end
        cma_pkg::ST_OUT: begin
          if (out_ready && cur_last && (e_pos != '0)) begin
            e_pos      <= e_pos - 1'b1;
            k          <= '0;
            issue_done <= 1'b0;
            rd_pend    <= 1'b0;
            acc        <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign smoothed    = smoothed_reg;
  assign last_of_run = last_reg;

  // one transaction at a time: never ready for input while a result is shown
  assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input accepted while a result is pending");

  // the final output of a signal returns the block to idle with the count cleared
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_of_run) |=>
      (state == cma_pkg::ST_IDLE) && (samples_seen == '0))
    else $error("signal end did not restart the sample count");

  // the divider only finishes while the control waits for it
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == cma_pkg::ST_WAIT))
    else $error("divider finished outside its wait state");

  // latched window is always a usable length
  assert property (@(posedge clk) disable iff (rst)
    (active_w != '0) && (active_w <= WIN_W'(MAX_WINDOW)))
    else $error("active window out of range");

endmodule
